>>> design/mnp_pkg.sv
// Shared types and constants for the MIDI note message parser.
// Used by every module of the block; has no dependencies of its own.
package mnp_pkg;

  localparam int PORTS_DEF  = 16;   // default number of per-port parse contexts
  localparam int PORT_CMP_W = 9;    // wide enough to compare against any port count up to 256
  localparam int EVQ_DEPTH  = 4;    // event queue entries between front and back
  localparam int EVQ_AW     = 2;    // event queue pointer width
  localparam int EVQ_CW     = 3;    // event queue fill count width

  localparam logic [6:0] NOTE_MIN_RST = 7'd21;
  localparam logic [6:0] NOTE_MAX_RST = 7'd108;

  // Upper nibble of the status bytes that open a message.
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;

  // Configuration register indexes.
  localparam logic REG_NOTE_MIN = 1'b0;
  localparam logic REG_NOTE_MAX = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_VEL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       is_note_off;
    logic [3:0] event_port;
    logic [4:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
  } note_event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } evq_status_t;

endpackage

>>> design/mnp_front.sv
// Front end: accepts bytes, runs the per-port parse table and emits note events.
// Depends on mnp_pkg.
module mnp_front #(
  parameter int PORTS = mnp_pkg::PORTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_port,
  input  logic [7:0]           in_byte,
  input  logic [6:0]           note_min,
  input  logic [6:0]           note_max,
  input  mnp_pkg::evq_status_t q_status,
  output logic                 ev_push,
  output mnp_pkg::note_event_t ev
);
  import mnp_pkg::*;

  phase_t     phase_r [PORTS];
  logic       off_r   [PORTS];
  logic [3:0] chan_r  [PORTS];
  logic [6:0] note_r  [PORTS];

  logic [PORT_CMP_W-1:0] port_ext;
  logic                  accept;
  logic                  hit;
  phase_t                ph_sel;
  logic                  off_sel;
  logic [3:0]            chan_sel;
  logic [6:0]            note_sel;
  phase_t                ph_nxt;
  logic                  wr_status;
  logic                  wr_note;
  logic                  emit;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign port_ext = {{(PORT_CMP_W-4){1'b0}}, in_port};
  assign hit      = port_ext < PORT_CMP_W'(PORTS);

  always_comb begin
    ph_sel   = PH_IDLE;
    off_sel  = 1'b0;
    chan_sel = 4'd0;
    note_sel = 7'd0;
    for (int i = 0; i < PORTS; i++) begin
      if (port_ext == PORT_CMP_W'(i)) begin
        ph_sel   = phase_r[i];
        off_sel  = off_r[i];
        chan_sel = chan_r[i];
        note_sel = note_r[i];
      end
    end
  end

  always_comb begin
    ph_nxt    = PH_IDLE;
    wr_status = 1'b0;
    wr_note   = 1'b0;
    emit      = 1'b0;
    unique case (ph_sel)
      PH_NOTE: begin
        if (in_byte >= {1'b0, note_min} && in_byte <= {1'b0, note_max}) begin
          wr_note = 1'b1;
          ph_nxt  = PH_VEL;
        end
      end
      PH_VEL: begin
        emit = !in_byte[7];
      end
      default: begin
        // Idle, and the unused phase code, look for a note status byte.
        if (in_byte[7:4] == STAT_NOTE_ON || in_byte[7:4] == STAT_NOTE_OFF) begin
          wr_status = 1'b1;
          ph_nxt    = PH_NOTE;
        end
      end
    endcase
  end

  assign ev_push         = accept && hit && emit;
  assign ev.is_note_off  = off_sel;
  assign ev.event_port   = in_port;
  assign ev.channel      = {1'b0, chan_sel} + 5'd1;
  assign ev.note         = note_sel;
  assign ev.velocity     = in_byte[6:0];

  for (genvar g = 0; g < PORTS; g++) begin : g_entry
    logic sel;
    assign sel = accept && hit && (port_ext == PORT_CMP_W'(g));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r[g] <= PH_IDLE;
      end else if (sel) begin
        phase_r[g] <= ph_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (sel && wr_status) begin
        off_r[g]  <= (in_byte[7:4] == STAT_NOTE_OFF);
        chan_r[g] <= in_byte[3:0];
      end
      if (sel && wr_note) begin
        note_r[g] <= in_byte[6:0];
      end
    end
  end

endmodule

>>> design/mnp_evq.sv
// Short event queue between the parse front end and the output stage.
// Depends on mnp_pkg.
module mnp_evq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mnp_pkg::note_event_t push_ev,
  input  logic                 pop,
  output mnp_pkg::note_event_t head_ev,
  output mnp_pkg::evq_status_t status
);
  import mnp_pkg::*;

  note_event_t       mem_r [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [EVQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [EVQ_CW-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == EVQ_CW'(EVQ_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_ev      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

endmodule

>>> design/mnp_back.sv
// Output stage: drains the event queue into a registered result stream.
// Depends on mnp_pkg.
module mnp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mnp_pkg::evq_status_t q_status,
  input  mnp_pkg::note_event_t head_ev,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mnp_pkg::note_event_t out_ev
);
  import mnp_pkg::*;

  logic        valid_r, valid_nxt;
  note_event_t ev_r;

  // The output register takes a new event whenever it is empty or being drained.
  assign pop       = !q_status.empty && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_ev    = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r <= head_ev;
    end
  end

endmodule

>>> design/midi_note_message_parser_unit.sv
// MIDI note message parser with one parse context per port. Throughput is one
// byte per cycle while the event queue is not full; the per-port table is read
// and updated in the accepting cycle, so bytes of the same port may follow back
// to back. An event passes from the front end through the four-entry event queue
// into the output register and leaves on out_tvalid. Synchronous reset sets every
// port to idle, empties the queue and loads note_min 21 and note_max 108.
module midi_note_message_parser_unit #(
  parameter int PORTS = mnp_pkg::PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [3:0] port, [11:4] midi_byte, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [3:0] event_port, [8:4] channel, [15:9] note,
                                   // [22:16] velocity, [23] zero
  output logic [0:0]  out_tuser,   // [0] is_note_off
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mnp_pkg::*;

  logic [6:0]  note_min_r;
  logic [6:0]  note_max_r;
  logic        cfg_wr;
  logic        ev_push;
  note_event_t ev_in;
  note_event_t head_ev;
  note_event_t out_ev;
  evq_status_t q_status;
  logic        q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {25'd0, (cfg_paddr[2] == REG_NOTE_MAX) ? note_max_r : note_min_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_min_r <= NOTE_MIN_RST;
      note_max_r <= NOTE_MAX_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_NOTE_MIN) begin
        note_min_r <= cfg_pwdata[6:0];
      end else begin
        note_max_r <= cfg_pwdata[6:0];
      end
    end
  end

  mnp_front #(
    .PORTS(PORTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_port  (in_tdata[3:0]),
    .in_byte  (in_tdata[11:4]),
    .note_min (note_min_r),
    .note_max (note_max_r),
    .q_status (q_status),
    .ev_push  (ev_push),
    .ev       (ev_in)
  );

  mnp_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .push_ev (ev_in),
    .pop     (q_pop),
    .head_ev (head_ev),
    .status  (q_status)
  );

  mnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_ev   (head_ev),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ev    (out_ev)
  );

  assign out_tdata = {1'b0, out_ev.velocity, out_ev.note, out_ev.channel, out_ev.event_port};
  assign out_tuser = out_ev.is_note_off;

`ifndef SYNTHESIS
  a_q_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("event queue reports full and empty together");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> !q_status.full)
    else $error("event pushed into a full queue");

  a_pop_feeds_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid)
    else $error("queue pop did not load the output register");

  a_channel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_ev.channel != 5'd0))
    else $error("event with channel zero");
`endif

endmodule

>>> verif/tb_midi_note_message_parser_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for midi_note_message_parser_unit: streams tagged MIDI bytes,
// predicts note events with a per-port parser of its own and checks every result.
// Depends on mnp_pkg and the parser's top level only.
module tb_midi_note_message_parser_unit;
  import mnp_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int NPORTS        = 16;

  typedef struct packed {
    logic [3:0] port;
    logic [7:0] mbyte;
  } midi_in_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [3:0] port, [11:4] midi_byte, [15:12] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [3:0] event_port, [8:4] channel, [15:9] note,
                                 // [22:16] velocity, [23] zero
  logic [0:0]  out_tuser;        // [0] is_note_off
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  midi_note_message_parser_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  midi_in_t    midi_bytes_pending[$];
  note_event_t note_events_expected[$];

  // Predictor copy of the configuration and of the per-port parse table.
  logic [6:0] note_lo = NOTE_MIN_RST;
  logic [6:0] note_hi = NOTE_MAX_RST;
  phase_t     parse_phase [NPORTS];
  logic       msg_is_off  [NPORTS];
  logic [3:0] msg_chan    [NPORTS];
  logic [6:0] msg_note    [NPORTS];

  int errors = 0;
  int in_gap_max = 3;
  int out_gap_max = 3;
  int hold_reqs = 0;
  int hold_seen = 0;
  int in_gap = 0;
  int out_stall = 0;
  int hold_cnt = 0;

  // Advances one port's parse state for an accepted byte and records any note event.
  function automatic void advance_parser(input logic [3:0] p, input logic [7:0] b);
    note_event_t ev;
    case (parse_phase[p])
      PH_NOTE: begin
        if (b < {1'b0, note_lo} || b > {1'b0, note_hi}) begin
          parse_phase[p] = PH_IDLE;
        end else begin
          msg_note[p] = b[6:0];
          parse_phase[p] = PH_VEL;
        end
      end
      PH_VEL: begin
        parse_phase[p] = PH_IDLE;
        if (!b[7]) begin
          ev.is_note_off = msg_is_off[p];
          ev.event_port  = p;
          ev.channel     = {1'b0, msg_chan[p]} + 5'd1;
          ev.note        = msg_note[p];
          ev.velocity    = b[6:0];
          note_events_expected = {note_events_expected, ev};
        end
      end
      default: begin
        parse_phase[p] = PH_IDLE;
        if (b[7:4] == STAT_NOTE_ON || b[7:4] == STAT_NOTE_OFF) begin
          msg_is_off[p] = (b[7:4] == STAT_NOTE_OFF);
          msg_chan[p] = b[3:0];
          parse_phase[p] = PH_NOTE;
        end
      end
    endcase
  endfunction

  // Appends one tagged byte to the driver's queue.
  function automatic void add_byte(input logic [3:0] p, input logic [7:0] b);
    midi_in_t item;
    item.port  = p;
    item.mbyte = b;
    midi_bytes_pending = {midi_bytes_pending, item};
  endfunction

  always @(posedge clk) begin : byte_driver
    logic taken;
    midi_in_t nxt;
    taken = in_tvalid && in_tready;
    if (taken) advance_parser(in_tdata[3:0], in_tdata[11:4]);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!in_tvalid || taken) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (midi_bytes_pending.size() > 0) begin
        nxt = midi_bytes_pending.pop_front();
        in_tdata <= {4'h0, nxt.mbyte, nxt.port};
        in_tvalid <= 1'b1;
        in_gap <= $urandom_range(0, in_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : event_monitor
    logic taken;
    int n;
    note_event_t want;
    taken = out_tvalid && out_tready;
    if (taken) begin
      if (note_events_expected.size() == 0) begin
        $display("%0t: unexpected note event, expected none actual tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = note_events_expected.pop_front();
        check_field("is_note_off", 8'(want.is_note_off), 8'(out_tuser[0]));
        check_field("event_port", 8'(want.event_port), 8'(out_tdata[3:0]));
        check_field("channel", 8'(want.channel), 8'(out_tdata[8:4]));
        check_field("note", 8'(want.note), 8'(out_tdata[15:9]));
        check_field("velocity", 8'(want.velocity), 8'(out_tdata[22:16]));
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
      hold_cnt <= 0;
    end else if (hold_seen != hold_reqs) begin
      // Long back-pressure so the event queue fills and the input side stalls.
      hold_seen <= hold_reqs;
      hold_cnt <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (taken) begin
      n = $urandom_range(0, out_gap_max);
      out_stall <= n;
      out_tready <= (n == 0);
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_tready <= (out_stall == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [7:0] status_byte(input logic is_off, input logic [3:0] chan);
    return {is_off ? STAT_NOTE_OFF : STAT_NOTE_ON, chan};
  endfunction

  function automatic logic [7:0] pick_note();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && note_lo <= note_hi) return 8'($urandom_range(note_lo, note_hi));
    if (r < 80) return {1'b0, note_lo};
    if (r < 85) return {1'b0, note_hi};
    if (r < 88) return {1'b0, note_lo} - 8'd1;
    if (r < 91) return {1'b0, note_hi} + 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_velocity();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic queue_message(input logic [3:0] p, input logic is_off, input logic [3:0] chan,
                               input logic [7:0] note, input logic [7:0] vel);
    add_byte(p, status_byte(is_off, chan));
    add_byte(p, note);
    add_byte(p, vel);
  endtask

  // Mostly complete messages with random content, some interleaved across two ports,
  // the rest loose bytes that break sequences or are ignored.
  task automatic queue_random_traffic(input int count);
    int done;
    int r;
    logic [3:0] p;
    logic [3:0] q;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      p = 4'($urandom_range(0, 15));
      if (r < 65) begin
        queue_message(p, 1'($urandom), 4'($urandom), pick_note(), pick_velocity());
        done += 3;
      end else if (r < 80) begin
        q = p + 4'($urandom_range(1, 15));
        add_byte(p, status_byte(1'($urandom), 4'($urandom)));
        add_byte(q, status_byte(1'($urandom), 4'($urandom)));
        add_byte(p, pick_note());
        add_byte(q, pick_note());
        add_byte(p, pick_velocity());
        add_byte(q, pick_velocity());
        done += 6;
      end else begin
        add_byte(p, 8'($urandom_range(0, 255)));
        done += 1;
      end
    end
  endtask

  // Polls on the falling edge so the driver's state is stable when read.
  task automatic wait_until_drained();
    @(negedge clk);
    while (midi_bytes_pending.size() != 0 || in_tvalid || note_events_expected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [6:0] val);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[6:0] = val;
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == REG_NOTE_MIN) note_lo = val;
    else note_hi = val;
  endtask

  task automatic run_phase(input logic [6:0] lo, input logic [6:0] hi, input int count,
                           input int in_max, input int out_max, input bit hold);
    wait_until_drained();
    write_reg(REG_NOTE_MIN, lo);
    write_reg(REG_NOTE_MAX, hi);
    in_gap_max <= in_max;
    out_gap_max <= out_max;
    queue_random_traffic(count);
    if (hold) hold_reqs <= hold_reqs + 1;
  endtask

  initial begin : test_sequence
    logic [6:0] lo;
    for (int i = 0; i < NPORTS; i++) begin
      parse_phase[i] = PH_IDLE;
      msg_is_off[i] = 1'b0;
      msg_chan[i] = '0;
      msg_note[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset limits 21..108.
    queue_message(4'd0, 1'b0, 4'd0, 8'd21, 8'd0);
    queue_message(4'd15, 1'b1, 4'd15, 8'd108, 8'd127);
    add_byte(4'd1, 8'h91);
    add_byte(4'd1, 8'd20);
    add_byte(4'd1, 8'h81);
    add_byte(4'd1, 8'd109);
    // A status byte in place of the note aborts and does not open a new message.
    add_byte(4'd2, 8'h92);
    add_byte(4'd2, 8'h85);
    add_byte(4'd2, 8'd64);
    // A status byte in place of the velocity drops the message.
    add_byte(4'd3, 8'h93);
    add_byte(4'd3, 8'd60);
    add_byte(4'd3, 8'h9F);
    add_byte(4'd3, 8'd60);
    queue_message(4'd6, 1'b0, 4'd7, 8'd64, 8'h80);
    add_byte(4'd7, 8'h00);
    add_byte(4'd7, 8'hA0);
    add_byte(4'd7, 8'hFF);
    add_byte(4'd4, 8'h94);
    add_byte(4'd5, 8'h85);
    add_byte(4'd4, 8'd64);
    add_byte(4'd5, 8'd64);
    add_byte(4'd4, 8'd100);
    add_byte(4'd5, 8'd0);

    run_phase(7'd0, 7'd127, 250, 0, 0, 1'b1);
    run_phase(7'd127, 7'd127, 150, 9, 9, 1'b0);
    run_phase(7'd0, 7'd0, 150, 9, 0, 1'b0);
    run_phase(7'd100, 7'd20, 150, 0, 9, 1'b0);
    lo = 7'($urandom_range(0, 127));
    run_phase(lo, 7'($urandom_range(lo, 127)), 250, 9, 9, 1'b0);
    run_phase(7'd60, 7'd72, 200, 4, 4, 1'b0);
    run_phase(NOTE_MIN_RST, NOTE_MAX_RST, 150, 9, 9, 1'b0);

    wait_until_drained();
    if (errors == 0) begin
      $display("midi_note_message_parser_unit test passed");
    end else begin
      $display("midi_note_message_parser_unit test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("midi_note_message_parser_unit test failed");
    $finish;
  end

endmodule
